@@ design/nabe_pkg.sv @@
// types and constants shared by the netascii block encoder modules
`timescale 1ns / 1ps

package nabe_pkg;

  localparam logic [1:0] MODE_TEXT   = 2'd0;
  localparam logic [1:0] MODE_OCTET  = 2'd1;
  localparam logic [1:0] MODE_SINGLE = 2'd2;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_EOF  = 1'b1;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } nabe_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [15:0] blk_num;
    logic [8:0]  byte_offset;
    logic        final_block;
    logic        last_of_run;
  } nabe_out_t;

endpackage

@@ design/nabe_step.sv @@
// combinational encode step: one item against the block state gives up to two results
`timescale 1ns / 1ps

module nabe_step #(
  parameter int BLOCK_BYTES = 512,
  localparam int FW = $clog2(BLOCK_BYTES),
  localparam int SW = $clog2(BLOCK_BYTES + 2)
) (
  input  nabe_pkg::nabe_in_t  item,
  input  logic [1:0]          mode,
  input  logic [15:0]         blk,
  input  logic [FW-1:0]       fill,
  output nabe_pkg::nabe_out_t res0,
  output nabe_pkg::nabe_out_t res1,
  output logic                two,
  output logic [15:0]         next_blk,
  output logic [FW-1:0]       next_fill
);
  import nabe_pkg::*;

  logic [SW-1:0] size;
  logic [SW-1:0] fill_x;
  logic          pre_close;
  logic [15:0]   blk_a;
  logic [SW-1:0] fill_a;
  logic          is_eof;
  logic          is_pair;
  logic          mid_close;
  logic [15:0]   blk_b;
  logic [SW-1:0] fill_b;
  logic [SW-1:0] fill_c;
  logic          post_close;
  logic [7:0]    second;

  always_comb begin
    size      = (mode == MODE_SINGLE) ? SW'(1) : SW'(BLOCK_BYTES);
    fill_x    = SW'(fill);
    pre_close = (fill_x >= size);
    blk_a     = pre_close ? blk + 16'd1 : blk;
    fill_a    = pre_close ? '0 : fill_x;

    is_eof    = (item.req_type == REQ_EOF);
    is_pair   = (mode == MODE_TEXT) && !is_eof &&
                ((item.in_byte == CHAR_LF) || (item.in_byte == CHAR_CR));
    // a pair that would straddle the block end opens the next block
    mid_close = is_pair && ((fill_a + SW'(1)) >= size);
    blk_b     = mid_close ? blk_a + 16'd1 : blk_a;
    fill_b    = mid_close ? '0 : fill_a;
    fill_c    = fill_b + (is_pair ? SW'(2) : SW'(1));
    post_close = (fill_c >= size);
    second    = (item.in_byte == CHAR_LF) ? CHAR_LF : CHAR_NUL;
  end

  always_comb begin
    res1.out_byte     = second;
    res1.byte_valid   = 1'b1;
    res1.blk_num      = blk_b;
    res1.byte_offset  = 9'(fill_b + SW'(1));
    res1.final_block  = 1'b0;
    res1.last_of_run  = 1'b1;
    priority if (is_eof) begin
      res0.out_byte     = CHAR_NUL;
      res0.byte_valid   = 1'b0;
      res0.blk_num      = (fill_a != '0) ? blk_a + 16'd1 : blk_a;
      res0.byte_offset  = 9'd0;
      res0.final_block  = 1'b1;
      res0.last_of_run  = 1'b1;
      two               = 1'b0;
      next_blk          = 16'd1;
      next_fill         = '0;
    end else if (is_pair) begin
      res0.out_byte     = CHAR_CR;
      res0.byte_valid   = 1'b1;
      res0.blk_num      = blk_b;
      res0.byte_offset  = 9'(fill_b);
      res0.final_block  = 1'b0;
      res0.last_of_run  = 1'b0;
      two               = 1'b1;
      next_blk          = post_close ? blk_b + 16'd1 : blk_b;
      next_fill         = post_close ? '0 : FW'(fill_c);
    end else begin
      res0.out_byte     = item.in_byte;
      res0.byte_valid   = 1'b1;
      res0.blk_num      = blk_b;
      res0.byte_offset  = 9'(fill_b);
      res0.final_block  = 1'b0;
      res0.last_of_run  = 1'b1;
      two               = 1'b0;
      next_blk          = post_close ? blk_b + 16'd1 : blk_b;
      next_fill         = post_close ? '0 : FW'(fill_c);
    end
  end

endmodule

@@ design/nabe_out_buf.sv @@
// two-entry result register that drains one result per transfer
`timescale 1ns / 1ps

module nabe_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  nabe_pkg::nabe_out_t load_res0,
  input  nabe_pkg::nabe_out_t load_res1,
  input  logic                load_two,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_stall,
  output nabe_pkg::nabe_out_t out_data
);
  import nabe_pkg::*;

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  nabe_out_t  e0_r;
  nabe_out_t  e0_nxt;
  nabe_out_t  e1_r;
  nabe_out_t  e1_nxt;
  logic       xfer;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = e0_r;
  assign xfer      = out_valid && !out_stall;
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && xfer);

  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    if (load) begin
      cnt_nxt = load_two ? 2'd2 : 2'd1;
      e0_nxt  = load_res0;
      e1_nxt  = load_res1;
    end else if (xfer) begin
      cnt_nxt = cnt_r - 2'd1;
      e0_nxt  = e1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result count out of range");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("loaded result not presented");
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !e0_r.last_of_run) |=> out_valid)
    else $error("second byte of a pair missing");
`endif

endmodule

@@ design/netascii_block_encoder_core.sv @@
// top level of the netascii block encoder: input register, encode step, result register
`timescale 1ns / 1ps

// Frames a byte stream into numbered blocks of BLOCK_BYTES bytes (one byte per block in
// single-byte mode), turning LF into CR LF and CR into CR NUL in text mode. Each item is
// held in an input register, encoded combinationally and placed in a two-entry result
// register that feeds the byte-wide result port. A CR or LF in text mode gives two results,
// which leave one byte per transfer; the next item is loaded only once the last result
// of the item is transferring. Each item passes the input register and then the result
// register before its first result is offered; a stalled result port stalls the
// input once the input register and the result register are both occupied. End of file
// gives one empty final-block result and restarts numbering at 1.
module netascii_block_encoder_core #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  nabe_pkg::nabe_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nabe_pkg::nabe_out_t out_data
);
  import nabe_pkg::*;

  localparam int FW = $clog2(BLOCK_BYTES);

  logic [1:0]    mode_r;
  logic          s1_valid_r;
  logic          s1_valid_nxt;
  nabe_in_t      s1_item_r;
  logic [15:0]   blk_r;
  logic [15:0]   blk_nxt;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;

  nabe_out_t     res0;
  nabe_out_t     res1;
  logic          two;
  logic [15:0]   step_blk;
  logic [FW-1:0] step_fill;
  logic          can_load;
  logic          move;
  logic          in_xfer;

  assign move     = s1_valid_r && can_load;
  assign in_stall = s1_valid_r && !can_load;
  assign in_xfer  = in_valid && !in_stall;

  nabe_step #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_step (
    .item      (s1_item_r),
    .mode      (mode_r),
    .blk       (blk_r),
    .fill      (fill_r),
    .res0      (res0),
    .res1      (res1),
    .two       (two),
    .next_blk  (step_blk),
    .next_fill (step_fill)
  );

  nabe_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (move),
    .load_res0 (res0),
    .load_res1 (res1),
    .load_two  (two),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (move) begin
      s1_valid_nxt = 1'b0;
    end
    blk_nxt  = move ? step_blk : blk_r;
    fill_nxt = move ? step_fill : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_OCTET;
      s1_valid_r <= 1'b0;
      blk_r      <= 16'd1;
      fill_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      s1_valid_r <= s1_valid_nxt;
      blk_r      <= blk_nxt;
      fill_r     <= fill_nxt;
    end
    if (in_xfer) begin
      s1_item_r <= in_data;
    end
  end

`ifndef SYNTHESIS
  a_final_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.final_block) |-> (!out_data.byte_valid && out_data.last_of_run))
    else $error("final block result carries data");
  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (move && s1_item_r.req_type == REQ_EOF) |=> (blk_r == 16'd1 && fill_r == '0))
    else $error("block state not restarted after end of file");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> (32'(fill_r) < BLOCK_BYTES))
    else $error("block fill beyond block size");
`endif

endmodule

@@ sim/netascii_block_encoder_core_test.sv @@
// testbench for the netascii block encoder core: directed table and random files against a predictor
`timescale 1ns / 1ps

module netascii_block_encoder_core_test;
  import nabe_pkg::*;

  localparam int BLOCK_BYTES  = 512;
  localparam int IDLE_PCT     = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 300;
  localparam int CALM_ITEMS   = 150;
  localparam int SHOWN_ERRORS = 40;
  localparam logic HI = 1'b1;
  localparam logic LO = 1'b0;

  typedef struct {
    logic [1:0] mode;
    nabe_in_t   item;
    bit         typed;
    nabe_out_t  want;
  } stim_row_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic [1:0] cfg_wr_data = MODE_OCTET;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  nabe_in_t   in_data     = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  nabe_out_t  out_data;

  // encoder state as predicted
  logic [1:0]  tx_mode   = MODE_OCTET;
  logic [15:0] cur_block = 16'd1;
  int unsigned blk_fill  = 0;

  nabe_out_t   pending_bytes[$];
  stim_row_t   stim_table[$];
  bit          calm         = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned idle_cycles  = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;

  netascii_block_encoder_core #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always #1 clk = ~clk;

  function automatic nabe_out_t make_result(logic [7:0] b, logic v, logic [15:0] blk,
                                            logic [8:0] off, logic fin, logic last);
    nabe_out_t r;
    r.out_byte     = b;
    r.byte_valid   = v;
    r.blk_num      = blk;
    r.byte_offset  = off;
    r.final_block  = fin;
    r.last_of_run  = last;
    return r;
  endfunction

  function automatic void advance_block();
    cur_block = cur_block + 16'd1;
    blk_fill  = 0;
  endfunction

  function automatic void encode_item(nabe_in_t item);
    int unsigned size_now;
    logic [7:0]  pair_tail;
    logic [15:0] eof_block;
    size_now = (tx_mode == MODE_SINGLE) ? 1 : BLOCK_BYTES;
    if (blk_fill >= size_now) advance_block();
    if (item.req_type == REQ_EOF) begin
      eof_block = (blk_fill != 0) ? cur_block + 16'd1 : cur_block;
      pending_bytes.push_back(make_result(CHAR_NUL, 1'b0, eof_block, 9'd0, 1'b1, 1'b1));
      cur_block = 16'd1;
      blk_fill  = 0;
    end else if (tx_mode == MODE_TEXT && (item.in_byte == CHAR_LF || item.in_byte == CHAR_CR)) begin
      pair_tail = (item.in_byte == CHAR_LF) ? CHAR_LF : CHAR_NUL;
      // pair never straddles a block boundary
      if (blk_fill + 1 >= size_now) advance_block();
      pending_bytes.push_back(make_result(CHAR_CR, 1'b1, cur_block, 9'(blk_fill), 1'b0, 1'b0));
      pending_bytes.push_back(make_result(pair_tail, 1'b1, cur_block, 9'(blk_fill + 1),
                                          1'b0, 1'b1));
      blk_fill += 2;
      if (blk_fill >= size_now) advance_block();
    end else begin
      pending_bytes.push_back(make_result(item.in_byte, 1'b1, cur_block, 9'(blk_fill),
                                          1'b0, 1'b1));
      blk_fill += 1;
      if (blk_fill >= size_now) advance_block();
    end
  endfunction

  function automatic void report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS)
      $display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got, want);
  endfunction

  function automatic void check_result(nabe_out_t got);
    nabe_out_t want;
    results_seen++;
    if (pending_bytes.size() == 0) begin
      report_mismatch("unexpected result, out_byte", 16'(got.out_byte), 16'h0);
      return;
    end
    want = pending_bytes.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch("out_byte", 16'(got.out_byte), 16'(want.out_byte));
    if (got.byte_valid !== want.byte_valid)
      report_mismatch("byte_valid", 16'(got.byte_valid), 16'(want.byte_valid));
    if (got.blk_num !== want.blk_num)
      report_mismatch("blk_num", got.blk_num, want.blk_num);
    if (got.byte_offset !== want.byte_offset)
      report_mismatch("byte_offset", 16'(got.byte_offset), 16'(want.byte_offset));
    if (got.final_block !== want.final_block)
      report_mismatch("final_block", 16'(got.final_block), 16'(want.final_block));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
  endfunction

  function automatic void add_row(logic [1:0] mode, logic req, logic [7:0] b,
                                  bit typed, nabe_out_t want);
    stim_row_t row;
    row.mode          = mode;
    row.item.req_type = req;
    row.item.in_byte  = b;
    row.typed         = typed;
    row.want          = want;
    stim_table.push_back(row);
  endfunction

  function automatic void build_table();
    nabe_out_t none;
    none = '0;
    add_row(MODE_OCTET,  REQ_EOF,  8'hA5, HI, make_result(8'h00, LO, 16'd1, 9'd0, HI, HI));
    add_row(MODE_OCTET,  REQ_DATA, 8'h00, HI, make_result(8'h00, HI, 16'd1, 9'd0, LO, HI));
    add_row(MODE_OCTET,  REQ_DATA, 8'hFF, HI, make_result(8'hFF, HI, 16'd1, 9'd1, LO, HI));
    add_row(MODE_OCTET,  REQ_DATA, CHAR_LF, HI, make_result(CHAR_LF, HI, 16'd1, 9'd2, LO, HI));
    add_row(MODE_OCTET,  REQ_DATA, CHAR_CR, HI, make_result(CHAR_CR, HI, 16'd1, 9'd3, LO, HI));
    // partly filled block closes on the switch to single-byte blocks
    add_row(MODE_SINGLE, REQ_DATA, 8'h55, HI, make_result(8'h55, HI, 16'd2, 9'd0, LO, HI));
    add_row(MODE_SINGLE, REQ_DATA, CHAR_CR, HI, make_result(CHAR_CR, HI, 16'd3, 9'd0, LO, HI));
    add_row(MODE_SINGLE, REQ_EOF,  8'hFF, HI, make_result(8'h00, LO, 16'd4, 9'd0, HI, HI));
    add_row(MODE_TEXT,   REQ_DATA, CHAR_LF, LO, none);
    add_row(MODE_TEXT,   REQ_DATA, CHAR_CR, LO, none);
    add_row(MODE_TEXT,   REQ_DATA, 8'h41, LO, none);
    add_row(MODE_TEXT,   REQ_DATA, 8'h00, LO, none);
    add_row(MODE_TEXT,   REQ_EOF,  CHAR_LF, HI, make_result(8'h00, LO, 16'd2, 9'd0, HI, HI));
    // unused mode acts as octet
    add_row(2'd3,        REQ_DATA, CHAR_LF, HI, make_result(CHAR_LF, HI, 16'd1, 9'd0, LO, HI));
    add_row(2'd3,        REQ_DATA, CHAR_CR, LO, none);
    add_row(2'd3,        REQ_EOF,  8'h5A, HI, make_result(8'h00, LO, 16'd2, 9'd0, HI, HI));
    add_row(MODE_TEXT,   REQ_DATA, 8'hFF, LO, none);
    add_row(MODE_TEXT,   REQ_DATA, 8'h80, LO, none);
    add_row(MODE_TEXT,   REQ_DATA, CHAR_CR, LO, none);
    add_row(MODE_SINGLE, REQ_DATA, 8'h7F, LO, none);
    add_row(MODE_OCTET,  REQ_DATA, 8'h01, LO, none);
    add_row(MODE_OCTET,  REQ_EOF,  8'h00, LO, none);
    add_row(MODE_OCTET,  REQ_EOF,  8'hC3, HI, make_result(8'h00, LO, 16'd1, 9'd0, HI, HI));
  endfunction

  function automatic logic [7:0] text_byte();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return CHAR_LF;
    if (pick < 30) return CHAR_CR;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CHAR_LF || b == CHAR_CR);
    return b;
  endfunction

  task automatic send_item(input logic req, input logic [7:0] b);
    int unsigned gap;
    nabe_in_t    item;
    gap = 0;
    item.req_type = req;
    item.in_byte  = b;
    if (!calm)
      while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    encode_item(item);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tx_mode = m;
  endtask

  task automatic send_stream(input int unsigned len, input bit with_eof);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(REQ_DATA, text_byte());
      if (i == len / 2 && len > 10 && $urandom_range(99) < 10) drain_results();
    end
    if (with_eof) send_item(REQ_EOF, 8'($urandom_range(255)));
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result(out_data);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_bytes.size());
      $display("netascii_block_encoder_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned base;
    int unsigned files;
    int unsigned pick;
    logic [1:0]  m;
    build_table();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].mode != tx_mode) write_mode(stim_table[i].mode);
      send_item(stim_table[i].item.req_type, stim_table[i].item.in_byte);
      if (stim_table[i].typed) begin
        void'(pending_bytes.pop_back());
        pending_bytes.push_back(stim_table[i].want);
      end
    end

    // pair meets the last slot of a text block and opens the next one, after a long output hold-off
    write_mode(MODE_TEXT);
    for (int unsigned i = 0; i < BLOCK_BYTES - 1; i++) begin
      send_item(REQ_DATA, plain_byte());
      if (i == 20) hold_off_req = 1'b1;
    end
    send_item(REQ_DATA, CHAR_LF);
    send_stream(20, 1);

    // octet file with no idling on either side
    write_mode(MODE_OCTET);
    calm = 1'b1;
    send_stream(CALM_ITEMS, 1);
    calm = 1'b0;

    base = items_sent;
    while (items_sent < base + RANDOM_ITEMS) begin
      m = ($urandom_range(99) < 45) ? MODE_TEXT : 2'($urandom_range(3));
      write_mode(m);
      files = $urandom_range(2, 6);
      for (int unsigned f = 0; f < files; f++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          send_item(REQ_EOF, 8'($urandom_range(255)));
        end else begin
          send_stream((pick < 95) ? $urandom_range(1, 40) : $urandom_range(100, 600),
                      !(f == files - 1 && $urandom_range(99) < 30));
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("%0d input transfers and %0d result transfers over all four modes,",
             items_sent, results_seen);
    $display("with pairs at block ends, mode switches mid-block, a long hold-off and a calm run");
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("netascii_block_encoder_core_test OK");
    end else begin
      $display("netascii_block_encoder_core_test NOT OK");
    end
    $finish;
  end

endmodule
